FILE: rtl/core/sfdb_pkg.sv
// types, codes and helpers shared by the sensor fetch sequencer core
// no dependencies

package sfdb_pkg;

	localparam int ACCEL_POINT_LIMIT = 32;
	localparam int GYRO_POINT_LIMIT  = 32;

	// operation codes of an input request
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_DONE    = 2'd1;
	localparam logic [1:0] OP_ACQUIRE = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ACCEL = 2'd0;
	localparam logic [1:0] CFG_GYRO  = 2'd1;
	localparam logic [1:0] CFG_AUX   = 2'd2;

	localparam logic [6:0] ACCEL_DEV_RST = 7'h1D;
	localparam logic [6:0] GYRO_DEV_RST  = 7'h6B;
	localparam logic [6:0] AUX_DEV_RST   = 7'h1E;

	// device register addresses
	localparam logic [7:0] REG_FIFO_SRC  = 8'h2F;
	localparam logic [7:0] REG_OUT_AUTO  = 8'hA8;
	localparam logic [7:0] REG_MAG_AUTO  = 8'h88;
	localparam logic [7:0] REG_AUX_OUT   = 8'h28;
	localparam logic [7:0] FIFO_OVR_MASK = 8'h40;
	localparam logic [7:0] FIFO_CNT_MASK = 8'h1F;
	localparam logic [7:0] MAG_BYTES     = 8'd6;

	typedef enum logic [2:0] {
		SLOT_STALE    = 3'd0,
		SLOT_FRESH    = 3'd1,
		SLOT_FRESHEST = 3'd2,
		SLOT_READING  = 3'd3,
		SLOT_WRITING  = 3'd4
	} slot_t;

	typedef enum logic [2:0] {
		PH_ACCEL_CNT = 3'd0,
		PH_ACCEL_DAT = 3'd1,
		PH_GYRO_CNT  = 3'd2,
		PH_GYRO_DAT  = 3'd3,
		PH_MAG       = 3'd4,
		PH_AUX_CNT   = 3'd5,
		PH_AUX_DAT   = 3'd6,
		PH_FINISH    = 3'd7
	} phase_t;

	typedef struct packed {
		logic [6:0] accel_dev;
		logic [6:0] gyro_dev;
		logic [6:0] aux_dev;
	} cfg_t;

	typedef struct packed {
		logic timeout;
		logic bus_err;
		logic fifo_ovr;
		logic buf_ovr;
	} flags_t;

	typedef struct packed {
		slot_t [1:0] slot;
		logic        fill_slot;
		logic        fetch_idle;
		logic        last_ok;
		phase_t      phase;
		flags_t      flags;
	} seq_state_t;

	typedef struct packed {
		logic       request_valid;
		logic [6:0] request_device;
		logic [7:0] request_register;
		logic [7:0] request_bytes;
		logic       target_slot;
		logic       acquire_granted;
		logic       acquire_slot;
		logic       frame_complete;
		flags_t     flags;
	} seq_result_t;

	// masked, capped sample count times six bytes
	function automatic logic [7:0] sample_bytes(input logic [7:0] status, input int limit);
		logic [5:0] n;
		logic [5:0] lim;
		n   = {1'b0, status[4:0] & FIFO_CNT_MASK[4:0]};
		lim = 6'(limit);
		if (n > lim)
			n = lim;
		return 8'(n) * MAG_BYTES;
	endfunction

endpackage

FILE: rtl/core/sfdb_step.sv
// next-state and result logic for one request of the fetch sequencer
// depends on sfdb_pkg

module sfdb_step import sfdb_pkg::*; (
	input  seq_state_t  cur,
	input  cfg_t        cfg,
	input  logic [1:0]  operation,
	input  logic        transfer_ok,
	input  logic [7:0]  fifo_status,
	output seq_state_t  nxt,
	output seq_result_t res
);

	always_comb begin
		seq_state_t s;
		seq_result_t r;
		logic go;
		s = cur;
		r = '0;
		go = 1'b1;
		case (operation)
			OP_TICK: begin
				if (!s.fetch_idle) begin
					if (s.last_ok) begin
						s.flags.timeout = 1'b1;
						go = 1'b0;
					end else begin
						// abandoned slot after a bus error goes back to stale
						s.flags.bus_err = 1'b1;
						if (s.slot[s.fill_slot] == SLOT_WRITING)
							s.slot[s.fill_slot] = SLOT_STALE;
						s.fetch_idle = 1'b1;
					end
				end
				if (go) begin
					if (s.slot[0] == SLOT_STALE) begin
						s.fill_slot = 1'b0;
					end else if (s.slot[1] == SLOT_STALE) begin
						s.fill_slot = 1'b1;
					end else begin
						s.flags.buf_ovr = 1'b1;
						go = 1'b0;
					end
				end
				if (go) begin
					s.slot[s.fill_slot] = SLOT_WRITING;
					s.fetch_idle = 1'b0;
					s.last_ok = 1'b1;
					s.phase = PH_ACCEL_CNT;
					r.request_valid = 1'b1;
					r.request_device = cfg.accel_dev;
					r.request_register = REG_FIFO_SRC;
					r.request_bytes = 8'd1;
				end
			end
			OP_DONE: begin
				if (!s.fetch_idle) begin
					s.last_ok = transfer_ok;
					if (transfer_ok) begin
						case (s.phase)
							PH_ACCEL_CNT, PH_GYRO_CNT, PH_AUX_CNT: begin
								if ((fifo_status & FIFO_OVR_MASK) != '0)
									s.flags.fifo_ovr = 1'b1;
							end
							default: ;
						endcase
						case (s.phase)
							PH_ACCEL_CNT: begin
								r.request_valid = 1'b1;
								r.request_device = cfg.accel_dev;
								r.request_register = REG_OUT_AUTO;
								r.request_bytes = sample_bytes(fifo_status, ACCEL_POINT_LIMIT);
								s.phase = PH_ACCEL_DAT;
							end
							PH_ACCEL_DAT: begin
								r.request_valid = 1'b1;
								r.request_device = cfg.gyro_dev;
								r.request_register = REG_FIFO_SRC;
								r.request_bytes = 8'd1;
								s.phase = PH_GYRO_CNT;
							end
							PH_GYRO_CNT: begin
								r.request_valid = 1'b1;
								r.request_device = cfg.gyro_dev;
								r.request_register = REG_OUT_AUTO;
								r.request_bytes = sample_bytes(fifo_status, GYRO_POINT_LIMIT);
								s.phase = PH_GYRO_DAT;
							end
							PH_GYRO_DAT: begin
								r.request_valid = 1'b1;
								r.request_device = cfg.accel_dev;
								r.request_register = REG_MAG_AUTO;
								r.request_bytes = MAG_BYTES;
								s.phase = PH_MAG;
							end
							PH_MAG: begin
								r.request_valid = 1'b1;
								r.request_device = cfg.aux_dev;
								r.request_register = REG_FIFO_SRC;
								r.request_bytes = 8'd1;
								s.phase = PH_AUX_CNT;
							end
							PH_AUX_CNT: begin
								r.request_valid = 1'b1;
								r.request_device = cfg.aux_dev;
								r.request_register = REG_AUX_OUT;
								r.request_bytes = sample_bytes(fifo_status, ACCEL_POINT_LIMIT);
								s.phase = PH_AUX_DAT;
							end
							PH_AUX_DAT: begin
								s.phase = PH_FINISH;
								if (s.slot[0] == SLOT_FRESH || s.slot[1] == SLOT_FRESH)
									s.slot[s.fill_slot] = SLOT_FRESHEST;
								else
									s.slot[s.fill_slot] = SLOT_FRESH;
								s.fetch_idle = 1'b1;
								r.frame_complete = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			OP_ACQUIRE: begin
				r.acquire_granted = 1'b1;
				if (s.slot[0] == SLOT_FRESHEST)
					r.acquire_slot = 1'b0;
				else if (s.slot[1] == SLOT_FRESHEST)
					r.acquire_slot = 1'b1;
				else if (s.slot[0] == SLOT_FRESH)
					r.acquire_slot = 1'b0;
				else if (s.slot[1] == SLOT_FRESH)
					r.acquire_slot = 1'b1;
				else
					r.acquire_granted = 1'b0;
				if (r.acquire_granted)
					s.slot[r.acquire_slot] = SLOT_READING;
			end
			default: begin
				if (s.slot[0] == SLOT_READING)
					s.slot[0] = SLOT_STALE;
				if (s.slot[1] == SLOT_READING)
					s.slot[1] = SLOT_STALE;
			end
		endcase
		if (r.request_valid)
			r.target_slot = s.fill_slot;
		r.flags = s.flags;
		nxt = s;
		res = r;
	end

endmodule

FILE: rtl/core/sensor_fetch_double_buffer_sequencer_core.sv
// top level of the sensor fetch sequencer: input stage, sequencer state, result stage
// depends on sfdb_pkg and sfdb_step
//
//  channel   direction  handshake            payload
//  in        to core    in_valid / in_stall  operation, transfer_ok, fifo_status
//  out       from core  out_valid/out_stall  request_*, target_slot, acquire_*, flags
//  cfg       to core    cfg_we               cfg_index, cfg_data
//
// one request per cycle sustained while out_stall is low; an accepted request is held in the input
// register, then loaded into the result register, from which it leaves
// reset sets both slots to stale, clears the phase and the flags, and loads the default device addresses
// out_stall holds the result register; the input register then fills and in_stall rises
// the sequencer state changes only when a request moves into the result register

module sensor_fetch_double_buffer_sequencer_core import sfdb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic       transfer_ok,
	input  logic [7:0] fifo_status,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       request_valid,
	output logic [6:0] request_device,
	output logic [7:0] request_register,
	output logic [7:0] request_bytes,
	output logic       target_slot,
	output logic       acquire_granted,
	output logic       acquire_slot,
	output logic       frame_complete,
	output logic       buffer_overrun_flag,
	output logic       fifo_overrun_flag,
	output logic       bus_error_flag,
	output logic       bus_timeout_flag
);

	cfg_t        cfg_q;
	seq_state_t  state_q;
	seq_state_t  state_nxt;
	seq_result_t res_nxt;
	seq_result_t res_s2;
	logic        valid_s1;
	logic        valid_s2;
	logic [1:0]  op_s1;
	logic        ok_s1;
	logic [7:0]  status_s1;
	logic        advance;
	logic        in_take;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{accel_dev: ACCEL_DEV_RST, gyro_dev: GYRO_DEV_RST, aux_dev: AUX_DEV_RST};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCEL: cfg_q.accel_dev <= cfg_data;
				CFG_GYRO:  cfg_q.gyro_dev  <= cfg_data;
				CFG_AUX:   cfg_q.aux_dev   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1     <= operation;
			ok_s1     <= transfer_ok;
			status_s1 <= fifo_status;
		end
	end

	sfdb_step u_step (
		.cur         (state_q),
		.cfg         (cfg_q),
		.operation   (op_s1),
		.transfer_ok (ok_s1),
		.fifo_status (status_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{slot: '{SLOT_STALE, SLOT_STALE}, fill_slot: 1'b0, fetch_idle: 1'b1,
				last_ok: 1'b1, phase: PH_ACCEL_CNT, flags: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid           = valid_s2;
	assign request_valid       = res_s2.request_valid;
	assign request_device      = res_s2.request_device;
	assign request_register    = res_s2.request_register;
	assign request_bytes       = res_s2.request_bytes;
	assign target_slot         = res_s2.target_slot;
	assign acquire_granted     = res_s2.acquire_granted;
	assign acquire_slot        = res_s2.acquire_slot;
	assign frame_complete      = res_s2.frame_complete;
	assign buffer_overrun_flag = res_s2.flags.buf_ovr;
	assign fifo_overrun_flag   = res_s2.flags.fifo_ovr;
	assign bus_error_flag      = res_s2.flags.bus_err;
	assign bus_timeout_flag    = res_s2.flags.timeout;

	// at most one slot is being filled
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.slot[0] == SLOT_WRITING && state_q.slot[1] == SLOT_WRITING))
		else $error("both slots in writing");

	// a running fetch always owns its fill slot
	a_fill_owned: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.fetch_idle |-> state_q.slot[state_q.fill_slot] == SLOT_WRITING)
		else $error("running fetch without a writing slot");

	// sticky flags never clear outside reset
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q.flags) & ~state_q.flags) == '0)
		else $error("sticky flag cleared");

	// a finished frame never carries a bus request
	a_finish_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_complete |-> !res_s2.request_valid)
		else $error("request issued on frame completion");

endmodule

FILE: dv/tb_top.sv
// self-checking bench for sensor_fetch_double_buffer_sequencer_core: directed and random requests
// with a local model of the double buffer sequencer, checked result by result in order
// depends on sfdb_pkg and the core rtl

module tb_top;
	import sfdb_pkg::*;

	localparam int SAMPLE_BYTES = 6;
	localparam int IDLE_NONE    = 0;
	localparam int IDLE_HEAVY   = 88;
	localparam int IDLE_MIXED   = 38;

	typedef struct packed {
		logic [1:0] op;
		logic       ok;
		logic [7:0] status;
	} seq_request_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_we      = 1'b0;
	logic [1:0] cfg_index   = CFG_ACCEL;
	logic [6:0] cfg_data    = 7'd0;
	logic       in_valid    = 1'b0;
	logic [1:0] operation   = OP_TICK;
	logic       transfer_ok = 1'b0;
	logic [7:0] fifo_status = 8'd0;
	logic       out_stall   = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       request_valid;
	logic [6:0] request_device;
	logic [7:0] request_register;
	logic [7:0] request_bytes;
	logic       target_slot;
	logic       acquire_granted;
	logic       acquire_slot;
	logic       frame_complete;
	logic       buffer_overrun_flag;
	logic       fifo_overrun_flag;
	logic       bus_error_flag;
	logic       bus_timeout_flag;

	sensor_fetch_double_buffer_sequencer_core i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.operation           (operation),
		.transfer_ok         (transfer_ok),
		.fifo_status         (fifo_status),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.request_valid       (request_valid),
		.request_device      (request_device),
		.request_register    (request_register),
		.request_bytes       (request_bytes),
		.target_slot         (target_slot),
		.acquire_granted     (acquire_granted),
		.acquire_slot        (acquire_slot),
		.frame_complete      (frame_complete),
		.buffer_overrun_flag (buffer_overrun_flag),
		.fifo_overrun_flag   (fifo_overrun_flag),
		.bus_error_flag      (bus_error_flag),
		.bus_timeout_flag    (bus_timeout_flag)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the sequencer state and device addresses
	slot_t      m_slot [2];
	logic       m_fill;
	logic       m_idle;
	logic       m_last_ok;
	phase_t     m_phase;
	flags_t     m_flags;
	logic [6:0] m_accel_dev;
	logic [6:0] m_gyro_dev;
	logic [6:0] m_aux_dev;

	seq_request_t queued_requests [$];
	seq_result_t  awaited_results [$];
	seq_request_t drv_request;
	seq_result_t  awaited;
	int           send_idle_pct = IDLE_NONE;
	int           stall_pct     = IDLE_NONE;
	int           mismatch_count = 0;

	// masked and capped sample count, as a byte count; also records the fifo overrun bit
	function automatic logic [7:0] fifo_read_bytes(input logic [7:0] status, input int limit);
		int n;
		if ((status & FIFO_OVR_MASK) != 8'd0)
			m_flags.fifo_ovr = 1'b1;
		n = int'(status & FIFO_CNT_MASK);
		if (n > limit)
			n = limit;
		return 8'(n * SAMPLE_BYTES);
	endfunction

	function automatic seq_result_t bus_read(input logic [6:0] dev, input logic [7:0] start,
			input logic [7:0] bytes);
		seq_result_t r;
		r = '0;
		r.request_valid    = 1'b1;
		r.request_device   = dev;
		r.request_register = start;
		r.request_bytes    = bytes;
		r.target_slot      = m_fill;
		return r;
	endfunction

	function automatic seq_result_t sequencer_step(input logic [1:0] op, input logic ok,
			input logic [7:0] status);
		seq_result_t r;
		int s;
		r = '0;
		s = -1;
		case (op)
		OP_TICK: begin
			if (!m_idle && m_last_ok) begin
				m_flags.timeout = 1'b1;
			end else begin
				// a stalled chain after a bus error is abandoned and restarted
				if (!m_idle) begin
					m_flags.bus_err = 1'b1;
					if (m_slot[m_fill] == SLOT_WRITING)
						m_slot[m_fill] = SLOT_STALE;
					m_idle = 1'b1;
				end
				if (m_slot[0] == SLOT_STALE)
					s = 0;
				else if (m_slot[1] == SLOT_STALE)
					s = 1;
				if (s < 0) begin
					m_flags.buf_ovr = 1'b1;
				end else begin
					m_fill     = s[0];
					m_slot[s]  = SLOT_WRITING;
					m_idle     = 1'b0;
					m_last_ok  = 1'b1;
					m_phase    = PH_ACCEL_CNT;
					r = bus_read(m_accel_dev, REG_FIFO_SRC, 8'd1);
				end
			end
		end
		OP_DONE: begin
			if (!m_idle) begin
				m_last_ok = ok;
				if (ok) begin
					case (m_phase)
					PH_ACCEL_CNT: begin
						r = bus_read(m_accel_dev, REG_OUT_AUTO,
							fifo_read_bytes(status, ACCEL_POINT_LIMIT));
						m_phase = PH_ACCEL_DAT;
					end
					PH_ACCEL_DAT: begin
						r = bus_read(m_gyro_dev, REG_FIFO_SRC, 8'd1);
						m_phase = PH_GYRO_CNT;
					end
					PH_GYRO_CNT: begin
						r = bus_read(m_gyro_dev, REG_OUT_AUTO,
							fifo_read_bytes(status, GYRO_POINT_LIMIT));
						m_phase = PH_GYRO_DAT;
					end
					PH_GYRO_DAT: begin
						r = bus_read(m_accel_dev, REG_MAG_AUTO, 8'(SAMPLE_BYTES));
						m_phase = PH_MAG;
					end
					PH_MAG: begin
						r = bus_read(m_aux_dev, REG_FIFO_SRC, 8'd1);
						m_phase = PH_AUX_CNT;
					end
					PH_AUX_CNT: begin
						r = bus_read(m_aux_dev, REG_AUX_OUT,
							fifo_read_bytes(status, ACCEL_POINT_LIMIT));
						m_phase = PH_AUX_DAT;
					end
					PH_AUX_DAT: begin
						m_phase = PH_FINISH;
						if (m_slot[0] == SLOT_FRESH || m_slot[1] == SLOT_FRESH)
							m_slot[m_fill] = SLOT_FRESHEST;
						else
							m_slot[m_fill] = SLOT_FRESH;
						m_idle = 1'b1;
						r.frame_complete = 1'b1;
					end
					default: ;
					endcase
				end
			end
		end
		OP_ACQUIRE: begin
			if (m_slot[0] == SLOT_FRESHEST)
				s = 0;
			else if (m_slot[1] == SLOT_FRESHEST)
				s = 1;
			else if (m_slot[0] == SLOT_FRESH)
				s = 0;
			else if (m_slot[1] == SLOT_FRESH)
				s = 1;
			if (s >= 0) begin
				m_slot[s] = SLOT_READING;
				r.acquire_granted = 1'b1;
				r.acquire_slot    = s[0];
			end
		end
		default: begin
			if (m_slot[0] == SLOT_READING)
				m_slot[0] = SLOT_STALE;
			if (m_slot[1] == SLOT_READING)
				m_slot[1] = SLOT_STALE;
		end
		endcase
		r.flags = m_flags;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// driver: predict on acceptance, then present the next queued request or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				awaited_results.push_back(sequencer_step(operation, transfer_ok, fifo_status));
			if (!in_valid || !in_stall) begin
				if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv_request = queued_requests.pop_front();
					in_valid    <= 1'b1;
					operation   <= drv_request.op;
					transfer_ok <= drv_request.ok;
					fifo_status <= drv_request.status;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result with no request outstanding");
					mismatch_count++;
				end else begin
					awaited = awaited_results.pop_front();
					check_field("request_valid", awaited.request_valid, request_valid);
					check_field("request_device", awaited.request_device, request_device);
					check_field("request_register", awaited.request_register, request_register);
					check_field("request_bytes", awaited.request_bytes, request_bytes);
					check_field("target_slot", awaited.target_slot, target_slot);
					check_field("acquire_granted", awaited.acquire_granted, acquire_granted);
					check_field("acquire_slot", awaited.acquire_slot, acquire_slot);
					check_field("frame_complete", awaited.frame_complete, frame_complete);
					check_field("buffer_overrun_flag", awaited.flags.buf_ovr,
						buffer_overrun_flag);
					check_field("fifo_overrun_flag", awaited.flags.fifo_ovr, fifo_overrun_flag);
					check_field("bus_error_flag", awaited.flags.bus_err, bus_error_flag);
					check_field("bus_timeout_flag", awaited.flags.timeout, bus_timeout_flag);
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic queue_request(input logic [1:0] op, input logic ok, input logic [7:0] status);
		seq_request_t q;
		q.op     = op;
		q.ok     = ok;
		q.status = status;
		queued_requests.push_back(q);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [6:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_ACCEL: m_accel_dev = val;
		CFG_GYRO:  m_gyro_dev  = val;
		default:   m_aux_dev   = val;
		endcase
	endtask

	task automatic wait_drained;
		do
			@(negedge clk);
		while (queued_requests.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// mostly whole fetch chains with random counts, plus stray and broken requests
	task automatic queue_random(input int count);
		int n;
		int r;
		int k;
		int cut;
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				queue_request(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				for (k = 0; k < 7; k++)
					queue_request(OP_DONE, 1'($urandom_range(0, 19) != 0),
						8'($urandom_range(0, 255)));
				n += 8;
			end else if (r < 62) begin
				queue_request(OP_ACQUIRE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				n++;
			end else if (r < 72) begin
				queue_request(OP_RELEASE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				n++;
			end else if (r < 85) begin
				queue_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
				n++;
			end else begin
				// chain cut short by a bus error or a new tick
				cut = $urandom_range(0, 6);
				queue_request(OP_TICK, 1'b1, 8'($urandom_range(0, 255)));
				for (k = 0; k < cut; k++)
					queue_request(OP_DONE, 1'b1, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) != 0)
					queue_request(OP_DONE, 1'b0, 8'($urandom_range(0, 255)));
				queue_request(OP_TICK, 1'b0, 8'($urandom_range(0, 255)));
				n += cut + 3;
			end
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input logic [6:0] accel,
			input logic [6:0] gyro, input logic [6:0] aux, input int count);
		write_register(CFG_ACCEL, accel);
		write_register(CFG_GYRO, gyro);
		write_register(CFG_AUX, aux);
		@(posedge clk);
		send_idle_pct <= send_pct;
		stall_pct     <= recv_pct;
		@(negedge clk);
		queue_random(count);
		wait_drained();
	endtask

	initial begin
		m_slot[0]   = SLOT_STALE;
		m_slot[1]   = SLOT_STALE;
		m_fill      = 1'b0;
		m_idle      = 1'b1;
		m_last_ok   = 1'b1;
		m_phase     = PH_ACCEL_CNT;
		m_flags     = '0;
		m_accel_dev = ACCEL_DEV_RST;
		m_gyro_dev  = GYRO_DEV_RST;
		m_aux_dev   = AUX_DEV_RST;

		// directed: ignored and empty requests, timeout, overrun bits, bus error, priorities
		queue_request(OP_DONE, 1'b1, 8'hFF);
		queue_request(OP_ACQUIRE, 1'b0, 8'h00);
		queue_request(OP_RELEASE, 1'b1, 8'hFF);
		queue_request(OP_TICK, 1'b0, 8'h00);
		queue_request(OP_TICK, 1'b1, 8'hFF);
		queue_request(OP_DONE, 1'b1, 8'hFF);
		queue_request(OP_DONE, 1'b1, 8'h00);
		queue_request(OP_DONE, 1'b1, 8'h00);
		queue_request(OP_DONE, 1'b1, 8'hA5);
		queue_request(OP_DONE, 1'b1, 8'h5A);
		queue_request(OP_DONE, 1'b1, 8'h40);
		queue_request(OP_DONE, 1'b1, 8'hBF);
		queue_request(OP_TICK, 1'b1, 8'h00);
		queue_request(OP_DONE, 1'b0, 8'h1F);
		queue_request(OP_TICK, 1'b0, 8'h00);
		queue_request(OP_DONE, 1'b1, 8'h1F);
		queue_request(OP_DONE, 1'b1, 8'h20);
		queue_request(OP_DONE, 1'b1, 8'h9E);
		queue_request(OP_DONE, 1'b1, 8'h00);
		queue_request(OP_DONE, 1'b1, 8'h00);
		queue_request(OP_DONE, 1'b1, 8'h01);
		queue_request(OP_DONE, 1'b1, 8'h00);
		queue_request(OP_TICK, 1'b1, 8'h00);
		queue_request(OP_ACQUIRE, 1'b1, 8'h00);
		queue_request(OP_ACQUIRE, 1'b1, 8'h00);
		queue_request(OP_RELEASE, 1'b0, 8'h00);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		run_phase(IDLE_NONE, IDLE_NONE, 7'd0, 7'd0, 7'd0, 450);
		run_phase(IDLE_HEAVY, IDLE_NONE, 7'd127, 7'd127, 7'd127, 450);
		run_phase(IDLE_NONE, IDLE_HEAVY, 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 450);
		run_phase(IDLE_MIXED, IDLE_MIXED, 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 450);

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/sfdb_pkg.sv
rtl/core/sfdb_step.sv
rtl/core/sensor_fetch_double_buffer_sequencer_core.sv
dv/tb_top.sv
